[sv/clique_minor_model_check_assert.svh]
// assertion macros for the checker file
`ifndef CLIQUE_MINOR_MODEL_CHECK_ASSERT_SVH
`define CLIQUE_MINOR_MODEL_CHECK_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CMMC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CMMC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/cmmc_pkg.sv]
`default_nettype none

package cmmc_pkg;

    // graph and partition size
    localparam int VERTEX_COUNT = 13;
    localparam int BAG_COUNT    = 7;

    // adjacency register layout
    localparam int ROWS_PER_REG = 4;
    localparam int REG_COUNT    = 4;
    localparam int CFG_DATA_W   = ROWS_PER_REG * VERTEX_COUNT;
    localparam int CFG_IDX_W    = $clog2(REG_COUNT);

    // step counter: one frontier expansion per cycle
    localparam int CNT_W     = $clog2(VERTEX_COUNT);
    localparam int BAG_IDX_W = $clog2(BAG_COUNT);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(VERTEX_COUNT - 1);

    typedef logic [VERTEX_COUNT-1:0] vmask_t;
    typedef vmask_t rows_t [VERTEX_COUNT];
    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_0_3  = 2'd0,
        REG_ROWS_4_7  = 2'd1,
        REG_ROWS_8_11 = 2'd2,
        REG_ROW_12    = 2'd3
    } reg_idx_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic             load;
        logic             step;
        logic [CNT_W-1:0] cnt;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/cmmc_cell.sv]
`default_nettype none

module cmmc_cell (
    input  wire                               clk,
    input  wire                               rst_n,
    input  cmmc_pkg::cell_ctrl_t              ctrl,
    input  wire  [cmmc_pkg::BAG_IDX_W-1:0]    cell_idx,
    input  cmmc_pkg::rows_t                   rows,
    input  cmmc_pkg::vmask_t                  bag_in,
    input  cmmc_pkg::vmask_t                  visitor_in,
    output cmmc_pkg::vmask_t                  visitor_out,
    output logic                              ok
);
    import cmmc_pkg::*;

    vmask_t bag_reg, seen_reg, visitor_reg;
    vmask_t seen_next, visitor_next;
    logic   pair_ok_reg, pair_ok_next;
    vmask_t reach, grow;
    logic   check_en;

    // neighbors of the whole bag and of the reached part
    always_comb
    begin
        reach = '0;
        grow  = '0;
        for (int v = 0; v < VERTEX_COUNT; v++)
        begin
            if (bag_reg[v])
                reach = reach | rows[v];
            if (seen_reg[v])
                grow = grow | rows[v];
        end
    end

    // visitor bag comes from a lower-numbered bag for the first cell_idx shifts
    assign check_en = (ctrl.cnt != '0) && (ctrl.cnt <= CNT_W'(cell_idx));

    // next state
    always_comb
    begin
        seen_next    = seen_reg;
        visitor_next = visitor_reg;
        pair_ok_next = pair_ok_reg;
        if (ctrl.load)
        begin
            seen_next    = bag_in & (~bag_in + VERTEX_COUNT'(1));
            visitor_next = bag_in;
            pair_ok_next = 1'b1;
        end
        else if (ctrl.step)
        begin
            seen_next    = seen_reg | (grow & bag_reg);
            visitor_next = visitor_in;
            if (check_en && ((reach & visitor_reg) == '0))
                pair_ok_next = 1'b0;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_ok_reg <= 1'b0;
        else
            pair_ok_reg <= pair_ok_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            bag_reg <= bag_in;
        seen_reg    <= seen_next;
        visitor_reg <= visitor_next;
    end

    assign visitor_out = visitor_reg;
    assign ok          = pair_ok_reg && (seen_reg == bag_reg);

endmodule

`default_nettype wire

[sv/clique_minor_model_check.sv]
`default_nettype none

// channel   direction  ports                                  handshake
// config    in         cfg_we, cfg_index, cfg_data            write when cfg_we high
// item      in         bag_zero .. bag_six                    start high, busy low
// result    out        is_model                               done high for one cycle
//
// an item is accepted while busy is low and is followed by busy cycles of
// frontier expansion in the ring of seven bag cells, one expansion per cycle, with the
// flag registered at the end of the last one, then one cycle with done high.
// a new item is taken in the cycle done shows, since busy is low again by then.
// reset clears the adjacency rows to zero and the sequencer to idle.
// the receiver cannot stall; each result is shown once.

module clique_minor_model_check (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [cmmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [cmmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                start,
    output logic                               busy,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_zero,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_one,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_two,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_three,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_four,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_five,
    input  wire  [cmmc_pkg::VERTEX_COUNT-1:0]  bag_six,
    output logic                               done,
    output logic                               is_model
);
    import cmmc_pkg::*;

    cfg_word_t        adj_reg [REG_COUNT];
    rows_t            rows;
    vmask_t           bags [BAG_COUNT];
    vmask_t           visitor [BAG_COUNT];
    logic [BAG_COUNT-1:0] cell_ok;
    cell_ctrl_t       ctrl;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             is_model_reg, is_model_next;
    logic             accept, last;

    // adjacency register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REG_COUNT; r++)
                adj_reg[r] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ROWS_0_3:  adj_reg[REG_ROWS_0_3]  <= cfg_data;
                REG_ROWS_4_7:  adj_reg[REG_ROWS_4_7]  <= cfg_data;
                REG_ROWS_8_11: adj_reg[REG_ROWS_8_11] <= cfg_data;
                REG_ROW_12:    adj_reg[REG_ROW_12]    <=
                                   {{(CFG_DATA_W - VERTEX_COUNT){1'b0}},
                                    cfg_data[VERTEX_COUNT-1:0]};
                default:       ;
            endcase
        end
    end

    // unpack one row per vertex
    always_comb
    begin
        for (int v = 0; v < VERTEX_COUNT; v++)
            rows[v] = adj_reg[v / ROWS_PER_REG][(v % ROWS_PER_REG) * VERTEX_COUNT +: VERTEX_COUNT];
    end

    // input bags in cell order
    assign bags[0] = bag_zero;
    assign bags[1] = bag_one;
    assign bags[2] = bag_two;
    assign bags[3] = bag_three;
    assign bags[4] = bag_four;
    assign bags[5] = bag_five;
    assign bags[6] = bag_six;

    // sequencer
    assign accept = start && !busy_reg;
    assign last   = busy_reg && (cnt_reg == STEP_LAST);

    always_comb
    begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        is_model_next = is_model_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (last)
        begin
            busy_next     = 1'b0;
            done_next     = 1'b1;
            is_model_next = &cell_ok;
        end
        else if (busy_reg)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_model_reg <= is_model_next;
    end

    assign ctrl.load = accept;
    assign ctrl.step = busy_reg;
    assign ctrl.cnt  = cnt_reg;

    // ring of bag cells, visitor bags move one cell up each cycle while busy
    for (genvar k = 0; k < BAG_COUNT; k++)
    begin : g_cell
        localparam int PREV = (k + BAG_COUNT - 1) % BAG_COUNT;
        cmmc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cell_idx    (BAG_IDX_W'(k)),
            .rows        (rows),
            .bag_in      (bags[k]),
            .visitor_in  (visitor[PREV]),
            .visitor_out (visitor[k]),
            .ok          (cell_ok[k])
        );
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign is_model = is_model_reg;

endmodule

`default_nettype wire

[sv/cmmc_check.sv]
`default_nettype none

`include "clique_minor_model_check_assert.svh"

module cmmc_check (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                start,
    input wire                                busy,
    input wire                                done
);

    // an accepted item makes the block busy
    `CMMC_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // each item that makes busy rise is followed by a done strobe
    `CMMC_ASSERT_IMP(a_latency, clk, rst_n, $rose(busy), ##13 done)

    // a result is shown only once the block is free again
    `CMMC_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // one strobe per item
    `CMMC_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)

endmodule

bind clique_minor_model_check cmmc_check u_cmmc_check (.*);

`default_nettype wire
